@@ src/qpm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package qpm_pkg;

    localparam int NUM_STAGES = 7;

    localparam int RATE_W  = 22;
    localparam int ANGLE_W = 17;
    localparam int THR_W   = 13;
    localparam int BASE_W  = 16;
    localparam int DEG_W   = 11;
    localparam int TERM_W  = 18;
    localparam int SUM_W   = 20;
    localparam int EZ_W    = 22;
    localparam int MAG_W   = 23;
    localparam int QUO_W   = 21;

    // 180/pi in unsigned Q6.24
    localparam logic [29:0] DEG_PER_RAD_Q24 = 30'd961263669;
    // ceil(2^24 / 5), exact quotient for dividends below 2^22
    localparam logic [21:0] RECIP5_Q24      = 22'd3355444;

    // 260/100 = 13/5
    localparam logic [8:0]  Z_RATE_MULT     = 9'd13;
    localparam logic [12:0] THROTTLE_ZERO   = 13'd1000;

    typedef enum logic [7:0] {
        REG_RATE_GAIN  = 8'd0,
        REG_ANGLE_GAIN = 8'd1
    } t_reg_index;

    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } t_pipe_ctl;

    typedef struct packed {
        logic signed [TERM_W-1:0]  px;
        logic signed [TERM_W-1:0]  py;
        logic signed [ANGLE_W-1:0] ez;
        logic signed [THR_W-1:0]   thr;
        logic signed [BASE_W-1:0]  base_front;
        logic signed [BASE_W-1:0]  base_left;
        logic signed [BASE_W-1:0]  base_back;
        logic signed [BASE_W-1:0]  base_right;
    } t_side;

    // floor(m / 5) by reciprocal multiply
    function automatic logic [QUO_W-1:0] div5(input logic [MAG_W-1:0] m);
        logic [44:0] p;
        p = 45'(m) * 45'(RECIP5_Q24);
        return p[44:24];
    endfunction

endpackage

`default_nettype wire

@@ src/qpm_rate_term.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Gyro rate -> derivative term: trunc0(mult * deg / 5), stages 0..2
module qpm_rate_term (
    input  wire logic                                i_clk,
    input  wire qpm_pkg::t_pipe_ctl                  i_ctl,
    input  wire logic signed [qpm_pkg::RATE_W-1:0]   i_rate,
    input  wire logic [8:0]                          i_mult,
    output logic signed [qpm_pkg::TERM_W-1:0]        o_term
);

    logic [qpm_pkg::RATE_W-1:0]  w_abs;
    logic [51:0]                 w_prod;
    logic [qpm_pkg::QUO_W-1:0]   w_quo;

    logic [qpm_pkg::DEG_W-1:0]   r_deg;
    logic                        r_neg0;
    logic [19:0]                 r_m;
    logic                        r_neg1;
    logic signed [qpm_pkg::TERM_W-1:0] r_term;

    always_comb begin
        w_abs  = i_rate[qpm_pkg::RATE_W-1] ? qpm_pkg::RATE_W'(-i_rate)
                                           : qpm_pkg::RATE_W'(i_rate);
        w_prod = 52'(w_abs) * 52'(qpm_pkg::DEG_PER_RAD_Q24);
        w_quo  = qpm_pkg::div5(qpm_pkg::MAG_W'(r_m));
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[0]) begin
            r_deg  <= w_prod[50:40];
            r_neg0 <= i_rate[qpm_pkg::RATE_W-1];
        end
        if (i_ctl.en[1]) begin
            r_m    <= 20'(i_mult) * 20'(r_deg);
            r_neg1 <= r_neg0;
        end
        if (i_ctl.en[2]) begin
            r_term <= r_neg1 ? -$signed({1'b0, w_quo[16:0]})
                             :  $signed({1'b0, w_quo[16:0]});
        end
    end

    assign o_term = r_term;

endmodule

`default_nettype wire

@@ src/qpm_motor_out.sv @@
`timescale 1ns / 1ps
`default_nettype none

// One motor: fold in the yaw correction with truncation toward zero,
// add throttle offset and saturate. Stages 4..6.
module qpm_motor_out (
    input  wire logic                               i_clk,
    input  wire qpm_pkg::t_pipe_ctl                 i_ctl,
    input  wire logic signed [qpm_pkg::SUM_W-1:0]   i_sum,
    input  wire logic signed [qpm_pkg::EZ_W-1:0]    i_ez19,
    input  wire logic                               i_z_sub,
    input  wire logic signed [qpm_pkg::THR_W-1:0]   i_thr,
    output logic signed [15:0]                      o_motor
);

    logic signed [31:0] w_s32;
    logic signed [31:0] w_zt;
    logic signed [31:0] w_t;
    logic [31:0]        w_abs;
    logic signed [22:0] w_q;
    logic signed [22:0] w_v;
    logic signed [22:0] w_r;

    logic [qpm_pkg::MAG_W-1:0]         r_mag4;
    logic                              r_neg4;
    logic signed [qpm_pkg::THR_W-1:0]  r_thr4;
    logic [qpm_pkg::QUO_W-1:0]         r_q5;
    logic                              r_neg5;
    logic signed [qpm_pkg::THR_W-1:0]  r_thr5;
    logic signed [15:0]                r_motor;

    always_comb begin
        // t = S*1280 +/- e*19; result is trunc0(t / 1280)
        w_s32 = 32'(i_sum);
        w_zt  = i_z_sub ? -32'(i_ez19) : 32'(i_ez19);
        w_t   = (w_s32 <<< 10) + (w_s32 <<< 8) + w_zt;
        w_abs = w_t[31] ? 32'(-w_t) : 32'(w_t);

        w_q = $signed({2'b00, r_q5});
        w_v = r_neg5 ? -w_q : w_q;
        w_r = w_v + 23'(r_thr5);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en[4]) begin
            r_mag4 <= w_abs[30:8];
            r_neg4 <= w_t[31];
            r_thr4 <= i_thr;
        end
        if (i_ctl.en[5]) begin
            r_q5   <= qpm_pkg::div5(r_mag4);
            r_neg5 <= r_neg4;
            r_thr5 <= r_thr4;
        end
        if (i_ctl.en[6]) begin
            if (w_r > 23'sd32767) begin
                r_motor <= 16'sh7fff;
            end else if (w_r < -23'sd32768) begin
                r_motor <= 16'sh8000;
            end else begin
                r_motor <= w_r[15:0];
            end
        end
    end

    assign o_motor = r_motor;

endmodule

`default_nettype wire

@@ src/quadrotor_pd_motor_mixer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Plus-frame quadrotor PD motor mixer.
// Input stream (s_axis): one control sample per transaction -- three gyro
// rates, three attitude corrections, throttle pulse and four base motor values.
// Output stream (m_axis): four saturated motor commands per sample.
// Config channel: i_cfg_index 0 = rate gain step, 1 = angle gain step; other
// indexes are ignored. Writes are always accepted; write only while idle.
// A sample passes from the input transaction to o_m_axis_tvalid through the
// seven register stages (degree multiply, gain multiply, divide-by-5, mix,
// yaw fold, divide-by-5, throttle add and saturate).
// Throughput: one sample per cycle. Each stage advances when the stage after
// it is empty or advancing, so a stall on i_m_axis_tready backs up through
// the stages and drops o_s_axis_tready only once all seven are full; nothing
// is lost or repeated.
// Reset clears all stage valid bits and both gain steps to zero.
module quadrotor_pd_motor_mixer (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,

    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [7:0]   i_cfg_index,
    input  wire logic [7:0]   i_cfg_data,

    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // gyro_rate_x[21:0], gyro_rate_y[43:22], gyro_rate_z[65:44],
    // angle_error_x[82:66], angle_error_y[99:83], angle_error_z[116:100],
    // throttle_pulse[128:117], base_front[144:129], base_left[160:145],
    // base_back[176:161], base_right[192:177], zero pad[199:193]
    input  wire logic [199:0] i_s_axis_tdata,

    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // motor_front[15:0], motor_left[31:16], motor_back[47:32], motor_right[63:48]
    output logic [63:0]       o_m_axis_tdata
);

    localparam int NS = qpm_pkg::NUM_STAGES;

    logic [7:0]           r_rate_step;
    logic [7:0]           r_angle_step;
    logic [NS-1:0]        r_vld;
    qpm_pkg::t_pipe_ctl   w_ctl;

    logic signed [qpm_pkg::RATE_W-1:0]  w_gyro_x, w_gyro_y, w_gyro_z;
    logic signed [qpm_pkg::ANGLE_W-1:0] w_ang_x, w_ang_y, w_ang_z;
    logic [8:0]                          w_rate_mult;
    logic [8:0]                          w_angle_mult;
    logic [qpm_pkg::ANGLE_W-1:0]         w_abs_x, w_abs_y;
    logic [25:0]                         w_prod_x, w_prod_y;
    qpm_pkg::t_side                      w_side;

    qpm_pkg::t_side r_side0, r_side1, r_side2;

    logic signed [qpm_pkg::TERM_W-1:0]  w_gx, w_gy, w_gz;
    logic signed [qpm_pkg::SUM_W-1:0]   r_sum_a, r_sum_b, r_sum_c, r_sum_d;
    logic signed [qpm_pkg::EZ_W-1:0]    r_ez19;
    logic signed [qpm_pkg::THR_W-1:0]   r_thr3;
    logic signed [qpm_pkg::EZ_W-1:0]    w_ez;

    logic signed [15:0] w_motor_a, w_motor_b, w_motor_c, w_motor_d;

    // config
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_step  <= 8'd0;
            r_angle_step <= 8'd0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                qpm_pkg::REG_RATE_GAIN:  r_rate_step  <= i_cfg_data;
                qpm_pkg::REG_ANGLE_GAIN: r_angle_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_ctl.en[NS-1] = !r_vld[NS-1] || i_m_axis_tready;
        for (int k = NS - 2; k >= 0; k--) begin
            w_ctl.en[k] = !r_vld[k] || w_ctl.en[k+1];
        end
    end

    assign o_s_axis_tready = w_ctl.en[0];
    assign o_m_axis_tvalid = r_vld[NS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_ctl.en[0]) begin
                r_vld[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (w_ctl.en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // unpack
    always_comb begin
        w_gyro_x = $signed(i_s_axis_tdata[21:0]);
        w_gyro_y = $signed(i_s_axis_tdata[43:22]);
        w_gyro_z = $signed(i_s_axis_tdata[65:44]);
        w_ang_x  = $signed(i_s_axis_tdata[82:66]);
        w_ang_y  = $signed(i_s_axis_tdata[99:83]);
        w_ang_z  = $signed(i_s_axis_tdata[116:100]);

        w_rate_mult  = 9'(r_rate_step) + 9'd1;
        w_angle_mult = 9'(r_angle_step) + 9'd1;

        // px = trunc0(e * (step+1) / 512)
        w_abs_x  = w_ang_x[qpm_pkg::ANGLE_W-1] ? qpm_pkg::ANGLE_W'(-w_ang_x)
                                               : qpm_pkg::ANGLE_W'(w_ang_x);
        w_abs_y  = w_ang_y[qpm_pkg::ANGLE_W-1] ? qpm_pkg::ANGLE_W'(-w_ang_y)
                                               : qpm_pkg::ANGLE_W'(w_ang_y);
        w_prod_x = 26'(w_abs_x) * 26'(w_angle_mult);
        w_prod_y = 26'(w_abs_y) * 26'(w_angle_mult);

        w_side.px  = w_ang_x[qpm_pkg::ANGLE_W-1] ? -$signed({1'b0, w_prod_x[25:9]})
                                                 :  $signed({1'b0, w_prod_x[25:9]});
        w_side.py  = w_ang_y[qpm_pkg::ANGLE_W-1] ? -$signed({1'b0, w_prod_y[25:9]})
                                                 :  $signed({1'b0, w_prod_y[25:9]});
        w_side.ez  = w_ang_z;
        w_side.thr = $signed({1'b0, i_s_axis_tdata[128:117]})
                   - $signed(qpm_pkg::THROTTLE_ZERO);
        w_side.base_front = $signed(i_s_axis_tdata[144:129]);
        w_side.base_left  = $signed(i_s_axis_tdata[160:145]);
        w_side.base_back  = $signed(i_s_axis_tdata[176:161]);
        w_side.base_right = $signed(i_s_axis_tdata[192:177]);
    end

    // side payload rides along with the rate terms
    always_ff @(posedge i_clk) begin
        if (w_ctl.en[0]) begin
            r_side0 <= w_side;
        end
        if (w_ctl.en[1]) begin
            r_side1 <= r_side0;
        end
        if (w_ctl.en[2]) begin
            r_side2 <= r_side1;
        end
    end

    qpm_rate_term u_rate_x (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_rate (w_gyro_x),
        .i_mult (w_rate_mult),
        .o_term (w_gx)
    );

    qpm_rate_term u_rate_y (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_rate (w_gyro_y),
        .i_mult (w_rate_mult),
        .o_term (w_gy)
    );

    qpm_rate_term u_rate_z (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_rate (w_gyro_z),
        .i_mult (qpm_pkg::Z_RATE_MULT),
        .o_term (w_gz)
    );

    // mix stage
    assign w_ez = qpm_pkg::EZ_W'(r_side2.ez);

    always_ff @(posedge i_clk) begin
        if (w_ctl.en[3]) begin
            r_sum_a <= qpm_pkg::SUM_W'(r_side2.base_front) - qpm_pkg::SUM_W'(w_gx)
                     - qpm_pkg::SUM_W'(w_gz) + qpm_pkg::SUM_W'(r_side2.px);
            r_sum_b <= qpm_pkg::SUM_W'(r_side2.base_left) - qpm_pkg::SUM_W'(w_gy)
                     + qpm_pkg::SUM_W'(w_gz) + qpm_pkg::SUM_W'(r_side2.py);
            r_sum_c <= qpm_pkg::SUM_W'(r_side2.base_back) + qpm_pkg::SUM_W'(w_gx)
                     - qpm_pkg::SUM_W'(w_gz) - qpm_pkg::SUM_W'(r_side2.px);
            r_sum_d <= qpm_pkg::SUM_W'(r_side2.base_right) + qpm_pkg::SUM_W'(w_gy)
                     + qpm_pkg::SUM_W'(w_gz) - qpm_pkg::SUM_W'(r_side2.py);
            // e * 19  (380/25600 = 19/1280)
            r_ez19  <= (w_ez <<< 4) + (w_ez <<< 1) + w_ez;
            r_thr3  <= r_side2.thr;
        end
    end

    qpm_motor_out u_motor_a (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sum   (r_sum_a),
        .i_ez19  (r_ez19),
        .i_z_sub (1'b0),
        .i_thr   (r_thr3),
        .o_motor (w_motor_a)
    );

    qpm_motor_out u_motor_b (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sum   (r_sum_b),
        .i_ez19  (r_ez19),
        .i_z_sub (1'b1),
        .i_thr   (r_thr3),
        .o_motor (w_motor_b)
    );

    qpm_motor_out u_motor_c (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sum   (r_sum_c),
        .i_ez19  (r_ez19),
        .i_z_sub (1'b0),
        .i_thr   (r_thr3),
        .o_motor (w_motor_c)
    );

    qpm_motor_out u_motor_d (
        .i_clk   (i_clk),
        .i_ctl   (w_ctl),
        .i_sum   (r_sum_d),
        .i_ez19  (r_ez19),
        .i_z_sub (1'b1),
        .i_thr   (r_thr3),
        .o_motor (w_motor_d)
    );

    assign o_m_axis_tdata = {w_motor_d, w_motor_c, w_motor_b, w_motor_a};

endmodule

`default_nettype wire
